// ===== hw/rtl/huff_pkg.sv =====
package huff_pkg;

	localparam int CODE_W           = 32;
	localparam int LEN_W            = 6;
	localparam int BYTE_W           = 8;
	localparam int CNT_W            = 4;
	localparam int TABLE_DEPTH      = 256;
	localparam int SYM_W            = 8;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = 1;
	localparam int QCNT_W           = 2;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_ENCODE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// one queued job for the packer
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} huff_op_t;

	typedef enum logic {
		PK_IDLE,
		PK_ENCODE
	} pack_state_t;

endpackage

// ===== hw/rtl/huff_front.sv =====
module huff_front import huff_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	output logic              op_valid,
	input  logic              op_ready,
	output huff_op_t          op
);

	localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LenW   = $clog2(LenCap + 1);

	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
	logic [LenW-1:0]   len_mem  [TABLE_DEPTH];

	logic              accept;
	logic [LenW-1:0]   len_wr;
	logic              valid_s1;
	logic              flush_s1;
	logic [CODE_W-1:0] code_s1;
	logic [LenW-1:0]   len_s1;

	assign in_ready = !valid_s1 || op_ready;
	assign accept   = in_valid && in_ready;

	// saturate the length before it goes into the table
	assign len_wr = (code_len > LEN_W'(LenCap)) ? LenW'(LenCap) : code_len[LenW-1:0];

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_LOAD) begin
			code_mem[symbol] <= code_bits;
			len_mem[symbol]  <= len_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1  <= code_mem[symbol];
			len_s1   <= len_mem[symbol];
			flush_s1 <= (req_type == REQ_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (req_type == REQ_ENCODE) || (req_type == REQ_FLUSH);
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign op_valid = valid_s1;
	assign op.flush = flush_s1;
	assign op.code  = code_s1;
	assign op.len   = LEN_W'(len_s1);

endmodule

// ===== hw/rtl/huff_queue.sv =====
module huff_queue import huff_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  huff_op_t in_op,
	output logic     out_valid,
	input  logic     out_ready,
	output huff_op_t out_op
);

	huff_op_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_op    = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/huff_pack.sv =====
module huff_pack import huff_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  huff_op_t          op,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	pack_state_t       state_q, state_d;
	logic [BYTE_W-1:0] buf_q, buf_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	logic              slot_free;
	logic              step;
	logic              emit;
	logic              emit_last;
	logic [CNT_W-1:0]  take;
	logic [CNT_W-1:0]  room;
	logic [BYTE_W-1:0] window;

	assign slot_free = !out_valid_q || out_ready;
	assign window    = code_q[CODE_W-1 -: BYTE_W];
	assign room      = CNT_W'(BYTE_W) - cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			PK_IDLE: begin
				if (op_valid && !op.flush && op.len != '0) begin
					state_d = PK_ENCODE;
				end
			end
			PK_ENCODE: begin
				if (step && rem_d == '0) begin
					state_d = PK_IDLE;
				end
			end
			default: state_d = PK_IDLE;
		endcase
	end

	// datapath and handshake
	always_comb begin
		op_ready  = 1'b0;
		step      = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		take      = '0;
		buf_d     = buf_q;
		cnt_d     = cnt_q;
		code_d    = code_q;
		rem_d     = rem_q;
		case (state_q)
			PK_IDLE: begin
				if (op_valid) begin
					if (op.flush) begin
						if (slot_free) begin
							op_ready  = 1'b1;
							emit      = 1'b1;
							emit_last = 1'b1;
							buf_d     = '0;
							cnt_d     = '0;
						end
					end else begin
						op_ready = 1'b1;
						// msb-align the code so the next bit is always on top
						code_d   = op.code << (LEN_W'(CODE_W) - op.len);
						rem_d    = op.len;
					end
				end
			end
			PK_ENCODE: begin
				if (cnt_q == CNT_W'(BYTE_W)) begin
					// a held full byte goes out once another bit shows up
					if (slot_free) begin
						step      = 1'b1;
						emit      = 1'b1;
						emit_last = (rem_q <= LEN_W'(BYTE_W));
						take      = (rem_q >= LEN_W'(BYTE_W)) ? CNT_W'(BYTE_W) : rem_q[CNT_W-1:0];
						buf_d     = window;
						cnt_d     = take;
						rem_d     = rem_q - LEN_W'(take);
						code_d    = code_q << take;
					end
				end else begin
					step   = 1'b1;
					take   = (rem_q >= LEN_W'(room)) ? room : rem_q[CNT_W-1:0];
					buf_d  = buf_q | (window >> cnt_q);
					cnt_d  = cnt_q + take;
					rem_d  = rem_q - LEN_W'(take);
					code_d = code_q << take;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PK_IDLE;
			buf_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			buf_q   <= buf_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
		rem_q  <= rem_d;
		if (emit) begin
			out_byte_q <= buf_q;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// huffman code bit packer
// input words carry req_type, symbol, code_bits and code_len on a valid/ready
// channel; output words carry one packed byte (first bit in the msb) plus last.
// a load word writes the code table and gives no output. an encode word looks
// up its symbol and appends the code bits; a byte that fills is held and sent
// only when the next bit arrives or a flush word comes. a flush word pads with
// zeros and always sends one byte with last set. the front takes one word per
// cycle while the queue accepts and reads the table into a stage register; a
// two-entry queue separates it from the packer, so loads keep flowing while
// the packer works and the queue has room. the packer moves up to eight bits
// per cycle unless a full byte waits for the output slot; an encode is first
// taken and msb-aligned, then moved in byte-sized chunks, and a flush is sent
// as it is taken. an encode or flush word passes the front stage register and
// a queue slot before the packer; out_valid comes from the single byte-wide
// output register, which can load a new byte while its old one is taken. when
// out_ready is low the packer holds at the next byte boundary, the queue fills
// and in_ready drops. reset empties buffer, queue and output register; the
// code table is not cleared and must be loaded before use.
module huffman_code_bit_packer_core import huff_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	logic     f_valid;
	logic     f_ready;
	huff_op_t f_op;
	logic     q_valid;
	logic     q_ready;
	huff_op_t q_op;

	huff_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.symbol   (symbol),
		.code_bits(code_bits),
		.code_len (code_len),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op       (f_op)
	);

	huff_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_op    (f_op),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_op   (q_op)
	);

	huff_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op_ready (q_ready),
		.op       (q_op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.last     (last)
	);

`ifndef SYNTHESIS
	// a word stalled at the front stage must not change under the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && $stable(f_op))
		else $error("front word changed while stalled");

	// the packer only pops a word that is there
	assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> q_valid)
		else $error("packer popped an empty queue");

	// a flush at the head of the queue is taken only together with an output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_op.flush |=> out_valid && last)
		else $error("flush did not produce a final byte");
`endif

endmodule

// ===== tb/sv/tb_huffman_code_bit_packer_core.sv =====
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_core import huff_pkg::*;;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int MAX_LEN = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 255;

	typedef struct packed {
		logic [1:0]        req;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} req_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_last;
	} packed_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        req_type = REQ_LOAD;
	logic [SYM_W-1:0]  symbol = '0;
	logic [CODE_W-1:0] code_bits = '0;
	logic [LEN_W-1:0]  code_len = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	req_word_t    pend_words[$];
	packed_byte_t exp_bytes[$];

	// predictor state
	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
	logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];
	logic [BYTE_W-1:0] acc_byte = '0;
	int unsigned       acc_bits = 0;

	logic in_taken = 1'b0;
	int   in_gap = 0;
	int   out_stall = 0;
	int   taken_cnt = 0;
	int   err_count = 0;
	int   cycle_cnt = 0;

	huffman_code_bit_packer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.symbol    (symbol),
		.code_bits (code_bits),
		.code_len  (code_len),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		if (err_count < 40)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// idling shifts between none, heavy and mixed as the run moves on
	function automatic int draw_wait();
		case ((taken_cnt / 37) % 3)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		endcase
	endfunction

	task automatic pack_word(input req_word_t w);
		int first;
		logic [CODE_W-1:0] code;
		case (w.req)
			REQ_LOAD: begin
				code_mem[w.sym] = w.code;
				len_mem[w.sym] = (int'(w.len) > MAX_LEN) ? LEN_W'(MAX_LEN) : w.len;
			end
			REQ_ENCODE: begin
				first = exp_bytes.size();
				code = code_mem[w.sym];
				for (int i = int'(len_mem[w.sym]); i > 0; i--) begin
					// a full byte leaves only when the next bit shows up
					if (acc_bits == BYTE_W) begin
						exp_bytes.push_back('{data: acc_byte, is_last: 1'b0});
						acc_byte = '0;
						acc_bits = 0;
					end
					acc_byte[BYTE_W-1-acc_bits] = code[i-1];
					acc_bits++;
				end
				if (exp_bytes.size() > first)
					exp_bytes[exp_bytes.size()-1].is_last = 1'b1;
			end
			REQ_FLUSH: begin
				exp_bytes.push_back('{data: acc_byte, is_last: 1'b1});
				acc_byte = '0;
				acc_bits = 0;
			end
			default: ;
		endcase
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold the word until it is taken
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pend_words.size() > 0) begin
				req_type <= pend_words[0].req;
				symbol <= pend_words[0].sym;
				code_bits <= pend_words[0].code;
				code_len <= pend_words[0].len;
				in_valid <= 1'b1;
				void'(pend_words.pop_front());
				in_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		packed_byte_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_bytes.size() == 0) begin
					note_mismatch($sformatf("unexpected word byte %02h last %0b", out_byte, last));
				end else begin
					e = exp_bytes.pop_front();
					if (out_byte !== e.data)
						note_mismatch($sformatf("out_byte %02h, want %02h", out_byte, e.data));
					if (last !== e.is_last)
						note_mismatch($sformatf("last %0b, want %0b", last, e.is_last));
				end
				out_stall = draw_wait();
			end
			if (in_valid && in_ready) begin
				pack_word('{req: req_type, sym: symbol, code: code_bits, len: code_len});
				taken_cnt++;
			end
			in_taken <= in_valid && in_ready;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_word(input logic [1:0] req, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		pend_words.push_back('{req: req, sym: sym, code: code, len: len});
	endtask

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEN_W'($urandom_range(33, 63));
			2, 3: return LEN_W'($urandom_range(13, 32));
			default: return LEN_W'($urandom_range(1, 12));
		endcase
	endfunction

	initial begin
		bit               was_loaded [TABLE_DEPTH];
		logic [SYM_W-1:0] loaded_syms[$];
		logic [SYM_W-1:0] s;
		int               counted;
		int               r;
		int               burst;

		foreach (was_loaded[i])
			was_loaded[i] = 1'b0;

		// directed words
		add_word(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
		add_word(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		add_word(REQ_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd63);
		add_word(REQ_LOAD, 8'h01, 32'h0000_0001, 6'd1);
		add_word(REQ_LOAD, 8'h02, 32'hFFFF_FF5A, 6'd8);
		add_word(REQ_LOAD, 8'h7F, 32'h1234_5678, 6'd33);
		add_word(REQ_UNUSED, 8'hAA, 32'h5555_AAAA, 6'h2A);
		add_word(REQ_FLUSH, 8'h00, 32'h0, 6'd0);       // empty buffer gives 00
		add_word(REQ_ENCODE, 8'h02, 32'h0, 6'd0);      // fills a byte, held
		add_word(REQ_FLUSH, 8'h00, 32'h0, 6'd0);       // full buffer sent as is
		add_word(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
		add_word(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
		add_word(REQ_ENCODE, 8'h00, 32'h0, 6'd0);      // no code, no output
		add_word(REQ_ENCODE, 8'h80, 32'h0, 6'd0);
		add_word(REQ_ENCODE, 8'h7F, 32'h0, 6'd0);
		add_word(REQ_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		add_word(REQ_LOAD, 8'h01, 32'h0, 6'd5);
		add_word(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
		add_word(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
		add_word(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
		add_word(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
		foreach (pend_words[i]) begin
			if (pend_words[i].req == REQ_LOAD && !was_loaded[pend_words[i].sym]) begin
				was_loaded[pend_words[i].sym] = 1'b1;
				loaded_syms.push_back(pend_words[i].sym);
			end
		end

		// random words: mostly loads and encodes of known symbols; bursts end in a flush
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				s = SYM_W'($urandom_range(0, 255));
				add_word(REQ_LOAD, s, $urandom, pick_len());
				if (!was_loaded[s]) begin
					was_loaded[s] = 1'b1;
					loaded_syms.push_back(s);
				end
				counted++;
			end else if (r < 75) begin
				add_word(REQ_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size()-1)],
					$urandom, LEN_W'($urandom_range(0, 63)));
				counted++;
			end else if (r < 85) begin
				add_word(REQ_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
					LEN_W'($urandom_range(0, 63)));
				counted++;
			end else if (r < 89) begin
				add_word(REQ_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
					LEN_W'($urandom_range(0, 63)));
			end else begin
				// a short message followed by its flush
				burst = $urandom_range(3, 8);
				repeat (burst)
					add_word(REQ_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size()-1)],
						32'h0, 6'd0);
				add_word(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
				counted += burst + 1;
			end
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (pend_words.size() != 0 || in_valid || exp_bytes.size() != 0);
		repeat (40) @(posedge clk);
		if (exp_bytes.size() != 0)
			note_mismatch($sformatf("%0d bytes never arrived", exp_bytes.size()));
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
